FILE: sv/svl_pkg.sv
// ----------------------------------------------------------------------------
// svl_pkg: shared types and codes of the sorted value list
// operation and status codes, the command broadcast to the cells and the
// comparison flags that each cell reports
// ----------------------------------------------------------------------------
package svl_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;

   typedef enum logic {
      ACTION_INSERT = 1'b0,
      ACTION_REMOVE = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // command seen by every cell in the row
   typedef struct packed {
      logic                         ins_en;
      logic                         rem_en;
      logic signed [ValueWidth-1:0] value;
   } cmd_type;

   // comparison results of one cell
   typedef struct packed {
      logic ins_ge;   // at or beyond the insert position
      logic rem_ge;   // at or beyond the first entry not below the value
      logic match;    // holds a live entry equal to the value
   } flags_type;

endpackage

FILE: sv/svl_cell.sv
// ----------------------------------------------------------------------------
// svl_cell: one slot of the sorted value list
// holds one entry, compares it against the broadcast value and takes its
// next value from itself, its left or right neighbour or the new value
// ----------------------------------------------------------------------------
module svl_cell (
   input  logic                                  clock,
   input  svl_pkg::cmd_type                      cmd,
   input  logic                                  in_use,
   input  logic                                  left_ins_ge,
   input  logic signed [svl_pkg::ValueWidth-1:0] left_entry,
   input  logic signed [svl_pkg::ValueWidth-1:0] right_entry,
   output logic signed [svl_pkg::ValueWidth-1:0] entry,
   output svl_pkg::flags_type                    flags
);

   logic signed [svl_pkg::ValueWidth-1:0] entry_ff;
   logic signed [svl_pkg::ValueWidth-1:0] entry_in;
   logic signed [svl_pkg::ValueWidth-1:0] value;

   assign value = $signed(cmd.value);
   assign entry = entry_ff;

   // unused slots count as beyond the insert point
   always_comb begin
      flags.ins_ge = !in_use || (entry_ff > value);
      flags.rem_ge = in_use && (entry_ff >= value);
      flags.match  = in_use && (entry_ff == value);
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins_en && flags.ins_ge) begin
         // first slot at the insert point takes the value, the rest shift right
         entry_in = left_ins_ge ? left_entry : value;
      end else if (cmd.rem_en && flags.rem_ge) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: sv/sorted_value_list_unit.sv
// ----------------------------------------------------------------------------
// sorted_value_list_unit: bounded sorted multiset of signed values
// a row of compare-and-shift cells keeps the entries in ascending order
// ----------------------------------------------------------------------------
// usage
//   request channel (req_valid, req_stall, req_action, req_value) carries one
//   operation per transfer: insert places the value after equal entries,
//   remove deletes the lowest-placed equal entry
//   response channel (rsp_valid, rsp_stall, rsp_status, rsp_entry_count)
//   returns exactly one transfer per request, in request order
// latency and throughput
//   the response is valid the cycle after the request transfer; one operation
//   per cycle unless a response waits on a stall, set by the compare and shift
//   that all cells of the row do in parallel against the broadcast value
// reset
//   synchronous, active high: the entry count goes to zero, the response
//   register is emptied and req_stall is held high so no request is taken;
//   the cell contents are left as they are
// stalls
//   a waiting response holds steady while rsp_stall is high; a new request
//   is still taken when the response register is empty or being drained
// ----------------------------------------------------------------------------
module sorted_value_list_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic signed [svl_pkg::ValueWidth-1:0] req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [svl_pkg::CountWidth-1:0]        rsp_entry_count
);

   localparam int CW = $clog2(CAPACITY + 1);

   // entry count
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // response register
   logic                               rsp_valid_ff;
   logic                               rsp_valid_in;
   svl_pkg::status_type                rsp_status_ff;
   svl_pkg::status_type                rsp_status_in;
   logic [svl_pkg::CountWidth-1:0]     rsp_count_ff;

   // cell row
   logic signed [svl_pkg::ValueWidth-1:0] entries [CAPACITY];
   svl_pkg::flags_type                    flags   [CAPACITY];
   logic [CAPACITY-1:0]                   match_vec;

   logic             accept;
   logic             is_insert;
   logic             full;
   logic             found;
   svl_pkg::cmd_type cmd;

   // a request transfer is held off during reset and while a response waits
   // on a stall
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_insert = (req_action == svl_pkg::ACTION_INSERT);
   assign full      = (count_ff == CW'(CAPACITY));

   // equal entries of a sorted row sit together, so any live match will do
   assign found = |match_vec;

   always_comb begin
      cmd.ins_en = accept && is_insert && !full;
      cmd.rem_en = accept && !is_insert && found;
      cmd.value  = req_value;
   end

   // row of cells, each wired to its neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                  left_ins_ge;
      logic signed [svl_pkg::ValueWidth-1:0] left_entry;
      logic signed [svl_pkg::ValueWidth-1:0] right_entry;

      if (i == 0) begin : g_first
         assign left_ins_ge = 1'b0;
         assign left_entry  = '0;
      end else begin : g_inner
         assign left_ins_ge = flags[i-1].ins_ge;
         assign left_entry  = entries[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entries[i];
      end else begin : g_body
         assign right_entry = entries[i+1];
      end

      assign match_vec[i] = flags[i].match;

      svl_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .in_use      (count_ff > CW'(i)),
         .left_ins_ge (left_ins_ge),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (entries[i]),
         .flags       (flags[i])
      );
   end

   // count and status of this operation
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = svl_pkg::STATUS_DONE;
      if (is_insert) begin
         if (full) begin
            rsp_status_in = svl_pkg::STATUS_FULL;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         if (found) begin
            count_in = count_ff - CW'(1);
         end else begin
            rsp_status_in = svl_pkg::STATUS_NOT_FOUND;
         end
      end
   end

   // response slot fills on a request transfer, empties on a response transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= svl_pkg::CountWidth'(count_in);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: sv/svl_checker.sv
// ----------------------------------------------------------------------------
// svl_checker: port-level checks of the sorted value list
// watches the request and response channels of the top level
// ----------------------------------------------------------------------------
module svl_checker #(
   parameter int CAPACITY = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_action,
   input logic signed [svl_pkg::ValueWidth-1:0] req_value,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [1:0]                            rsp_status,
   input logic [svl_pkg::CountWidth-1:0]        rsp_entry_count
);

   // no response straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every request transfer gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("request transfer without response");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_entry_count)))
      else $error("stalled response changed");

   // a dropped insert is only reported when the store is full
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == svl_pkg::STATUS_FULL) |->
         (rsp_entry_count == svl_pkg::CountWidth'(CAPACITY)))
      else $error("full status with count below capacity");

   // every response carries a defined status code; in the design only remove
   // requests report not found, and only insert requests report full
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == svl_pkg::STATUS_DONE ||
                     rsp_status == svl_pkg::STATUS_NOT_FOUND ||
                     rsp_status == svl_pkg::STATUS_FULL))
      else $error("undefined status code");

endmodule

bind sorted_value_list_unit svl_checker #(.CAPACITY(CAPACITY)) u_svl_checker (.*);

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_value_list_unit
// a backlog of insert and remove requests, directed first and then random in
// fill, mixed and drain phases, is pushed through the request channel in
// bursts; every accepted request updates a software copy of the sorted store,
// whose status and count are checked against each response transfer
// ----------------------------------------------------------------------------
module tb;

   localparam int Capacity = 16;
   localparam logic signed [svl_pkg::ValueWidth-1:0] MinValue = 32'sh8000_0000;
   localparam logic signed [svl_pkg::ValueWidth-1:0] MaxValue = 32'sh7FFF_FFFF;

   // software view of the store: entries kept ascending, n live ones
   typedef struct packed {
      logic [Capacity-1:0][svl_pkg::ValueWidth-1:0] vals;
      int                                           n;
   } store_type;

   typedef struct packed {
      svl_pkg::action_type                   action;
      logic signed [svl_pkg::ValueWidth-1:0] value;
      logic                                  drain_first;   // hold until all responses are back
   } pending_item_type;

   typedef struct packed {
      svl_pkg::status_type            status;
      logic [svl_pkg::CountWidth-1:0] count;
   } rsp_expect_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_stall;
   logic                                  req_action = 1'b0;
   logic signed [svl_pkg::ValueWidth-1:0] req_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_stall = 1'b0;
   logic [1:0]                            rsp_status;
   logic [svl_pkg::CountWidth-1:0]        rsp_entry_count;

   pending_item_type req_backlog[$];
   rsp_expect_type   expected_rsp[$];

   store_type plan_store = '0;   // tracks contents while the backlog is built
   store_type live_store = '0;   // tracks contents as requests are accepted

   int error_count   = 0;
   int rsp_seen      = 0;
   int n_queued      = 0;
   int n_inserts     = 0;
   int n_removes     = 0;
   int n_full_drops  = 0;
   int n_no_match    = 0;
   int peak_fill     = 0;

   sorted_value_list_unit #(
      .CAPACITY(Capacity)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // apply one operation to a store copy and give the response it must cause
   function automatic void update_sorted_store(
      inout  store_type                             st,
      input  svl_pkg::action_type                   act,
      input  logic signed [svl_pkg::ValueWidth-1:0] v,
      output svl_pkg::status_type                   status,
      output logic [svl_pkg::CountWidth-1:0]        count
   );
      int          pos;
      logic        found;
      logic [31:0] n_bits;
      status = svl_pkg::STATUS_DONE;
      pos    = st.n;
      found  = 1'b0;
      if (act == svl_pkg::ACTION_INSERT) begin
         if (st.n >= Capacity) begin
            status = svl_pkg::STATUS_FULL;
         end else begin
            // new value goes after every equal entry: first strictly greater one
            for (int i = 0; i < st.n; i++) begin
               if (!found && $signed(st.vals[i]) > v) begin
                  pos   = i;
                  found = 1'b1;
               end
            end
            for (int i = st.n; i > pos; i--) begin
               st.vals[i] = st.vals[i-1];
            end
            st.vals[pos] = v;
            st.n++;
         end
      end else begin
         // lowest-placed equal entry goes
         for (int i = 0; i < st.n; i++) begin
            if (!found && $signed(st.vals[i]) == v) begin
               pos   = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            status = svl_pkg::STATUS_NOT_FOUND;
         end else begin
            for (int i = pos; i < st.n - 1; i++) begin
               st.vals[i] = st.vals[i+1];
            end
            st.n--;
         end
      end
      n_bits = st.n;
      count  = n_bits[svl_pkg::CountWidth-1:0];
   endfunction

   task automatic queue_op(input svl_pkg::action_type act,
                           input logic signed [svl_pkg::ValueWidth-1:0] v,
                           input logic drain);
      svl_pkg::status_type            s;
      logic [svl_pkg::CountWidth-1:0] c;
      update_sorted_store(plan_store, act, v, s, c);
      req_backlog.push_back('{action: act, value: v, drain_first: drain});
   endtask

   // ---------------------------------------------------------------------------
   // request driver: bursts of random length separated by random gaps; a
   // payload stays put while the block stalls it, and each accepted transfer
   // is predicted at once
   // ---------------------------------------------------------------------------
   int gap_left   = 0;
   int burst_left = 1;

   always @(posedge clock) begin
      logic                           took;
      logic                           next_valid;
      pending_item_type               item;
      svl_pkg::status_type            want_status;
      logic [svl_pkg::CountWidth-1:0] want_count;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            update_sorted_store(live_store, svl_pkg::action_type'(req_action), req_value,
                                want_status, want_count);
            expected_rsp.push_back('{status: want_status, count: want_count});
            if (svl_pkg::action_type'(req_action) == svl_pkg::ACTION_INSERT) n_inserts++;
            else n_removes++;
            if (want_status == svl_pkg::STATUS_FULL) n_full_drops++;
            if (want_status == svl_pkg::STATUS_NOT_FOUND) n_no_match++;
            if (live_store.n > peak_fill) peak_fill = live_store.n;
         end
         // a new payload only once the current one has gone
         if (!req_valid || took) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() > 0 &&
                         !(req_backlog[0].drain_first && expected_rsp.size() != 0)) begin
               item = req_backlog.pop_front();
               req_action <= item.action;
               req_value  <= item.value;
               next_valid = 1'b1;
               if (burst_left <= 1) begin
                  // some bursts run back to back with no gap at all
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
            req_valid <= next_valid;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response stall: a pattern that changes mode every so often, plus two long
   // hold-offs during which the sender keeps offering so the block backs up
   // ---------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             hold_left  = 0;
   int             hold_at    = 300;
   int             holds_done = 0;

   always @(posedge clock) begin
      logic next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         next_stall = 1'b0;
         if (hold_left == 0 && holds_done < 2 && rsp_seen >= hold_at) begin
            hold_left = 400;
            holds_done++;
            hold_at += 900;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left  = $urandom_range(16, 128);
               stall_mode = stall_mode_type'($urandom_range(0, 3));
            end
            mode_left--;
            case (stall_mode)
               STALL_NONE:  next_stall = 1'b0;
               STALL_LIGHT: next_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
               default:     next_stall = ~rsp_stall;
            endcase
         end
         rsp_stall <= next_stall;
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor: each transfer against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_expect_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsp.size() == 0) begin
            if (error_count < 10)
               $display("response %0d with nothing outstanding: status %0d count %0d",
                        rsp_seen, rsp_status, rsp_entry_count);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_status !== want.status || rsp_entry_count !== want.count) begin
               if (error_count < 10)
                  $display({"response %0d mismatch: status exp %0d got %0d, ",
                            "count exp %0d got %0d"},
                           rsp_seen, want.status, rsp_status, want.count,
                           rsp_entry_count);
               error_count++;
            end
         end
      end
   end

   // generous cap, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus build, reset and end of run
   // ---------------------------------------------------------------------------
   initial begin
      int                                    phase_left;
      int                                    insert_pct;
      svl_pkg::action_type                   act;
      logic signed [svl_pkg::ValueWidth-1:0] v;

      // directed: empty remove, extremes, duplicates, missing value, full store
      queue_op(svl_pkg::ACTION_REMOVE, 0, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, MaxValue, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, MinValue, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, 0, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, -1, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, 5, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, 5, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, 5, 1'b0);
      queue_op(svl_pkg::ACTION_REMOVE, 5, 1'b0);
      queue_op(svl_pkg::ACTION_REMOVE, 7, 1'b0);
      queue_op(svl_pkg::ACTION_REMOVE, MinValue, 1'b0);
      queue_op(svl_pkg::ACTION_REMOVE, MaxValue, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, MaxValue, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, MinValue, 1'b0);
      for (int i = 0; i < 10; i++) queue_op(svl_pkg::ACTION_INSERT, i * 7 - 30, 1'b0);
      queue_op(svl_pkg::ACTION_INSERT, 1, 1'b0);
      queue_op(svl_pkg::ACTION_REMOVE, 5, 1'b0);

      // random: phases leaning to fill, churn or drain; many removes hit a
      // stored value so the shift paths get real work
      phase_left = 0;
      insert_pct = 50;
      for (int k = 0; k < 2000; k++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
               0:       insert_pct = 85;
               1:       insert_pct = 50;
               default: insert_pct = 15;
            endcase
         end
         phase_left--;
         act = ($urandom_range(0, 99) < insert_pct) ? svl_pkg::ACTION_INSERT
                                                    : svl_pkg::ACTION_REMOVE;
         case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4:    v = int'($urandom_range(0, 8)) - 4;
            5: begin
               case ($urandom_range(0, 3))
                  0:       v = MinValue;
                  1:       v = MaxValue;
                  2:       v = 0;
                  default: v = -1;
               endcase
            end
            default: begin
               if (plan_store.n > 0) begin
                  v = plan_store.vals[$urandom_range(0, plan_store.n - 1)];
                  if ($urandom_range(0, 2) == 0) v = v + int'($urandom_range(0, 2)) - 1;
               end else begin
                  v = $urandom;
               end
            end
         endcase
         queue_op(act, v, (k % 450) == 449);
      end
      n_queued = req_backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // every request taken, every response back, then a short tail
      while (n_inserts + n_removes < n_queued) @(posedge clock);
      while (rsp_seen < n_queued) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d transfers: %0d inserts, %0d removes, peak fill %0d of %0d",
               rsp_seen, n_inserts, n_removes, peak_fill, Capacity);
      $display("%0d inserts refused on a full store, %0d removes without a match",
               n_full_drops, n_no_match);
      if (error_count == 0 && expected_rsp.size() == 0 && rsp_seen == n_queued) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
